// ----- design/tcspg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspg_pkg
// Shared widths, defaults and types of the three-channel step pulse generator.
// ----------------------------------------------------------------------------
package tcspg_pkg;

   localparam int PWM_SLOTS_DEFAULT   = 10;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int POS_WIDTH_DEFAULT   = 32;

   localparam int LIMIT_WIDTH   = 16;
   localparam int DUTY_WIDTH    = 4;
   localparam int OUT_POS_WIDTH = 32;

   localparam int REQ_DATA_WIDTH = 56;
   localparam int RSP_DATA_WIDTH = 104;

   typedef struct packed {
      logic fire;
      logic level_next;
   } chan_status_type;

endpackage

// ----- design/tcspg_channel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspg_channel
// One step channel: saturating tick counter, limit compare, step level and
// position register.
// ----------------------------------------------------------------------------
module tcspg_channel
   import tcspg_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int POS_WIDTH   = POS_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [LIMIT_WIDTH-1:0] limit,
   input  logic                   enable,
   input  logic                   count_up,
   output chan_status_type        status,
   output logic [POS_WIDTH-1:0]   pos_next
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_rise;
   logic                   level_ff, level_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   fire;

   always_comb begin
      count_rise = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
      fire       = enable && (CMP_WIDTH'(count_rise) >= CMP_WIDTH'(limit));
      count_in   = fire ? '0 : count_rise;
      level_in   = fire ? ~level_ff : level_ff;
      if (!fire) begin
         pos_in = pos_ff;
      end else if (count_up) begin
         pos_in = pos_ff + POS_WIDTH'(1);
      end else begin
         pos_in = pos_ff + {POS_WIDTH{1'b1}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         level_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         level_ff <= level_in;
         pos_ff   <= pos_in;
      end
   end

   assign status.fire       = fire;
   assign status.level_next = level_in;
   assign pos_next          = pos_in;

endmodule

// ----- design/tcspg_heater_pwm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspg_heater_pwm
// Slot counter and output level of the heater PWM.
// ----------------------------------------------------------------------------
module tcspg_heater_pwm
   import tcspg_pkg::*;
#(
   parameter int PWM_SLOTS = PWM_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [DUTY_WIDTH-1:0] duty,
   output logic                  heater_next
);

   localparam int SLOT_WIDTH = $clog2(PWM_SLOTS);

   logic [SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic                  heater_ff, heater_in;

   always_comb begin
      heater_in = heater_ff;
      if (slot_ff == '0) begin
         heater_in = 1'b1;
      end
      if (DUTY_WIDTH'(slot_ff) == duty) begin
         heater_in = 1'b0;
      end
      if (slot_ff == SLOT_WIDTH'(PWM_SLOTS - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + SLOT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         heater_ff <= 1'b0;
      end else if (advance) begin
         slot_ff   <= slot_in;
         heater_ff <= heater_in;
      end
   end

   assign heater_next = heater_in;

endmodule

// ----- design/three_channel_step_pulse_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_step_pulse_generator_core
// Three step channels and a heater PWM, advanced by one tick item at a time.
// ----------------------------------------------------------------------------
// Every accepted item is one timer tick and yields exactly one result item.
// An item is taken into an input register, passes through the counter, compare
// and toggle logic of the three channels and the heater PWM, and lands in the
// result register, so the block sustains one item per cycle while rsp_tready
// does not hold the result register full. The input side keeps taking items
// while the input register is empty or the result register is empty or being
// drained in that cycle.
module three_channel_step_pulse_generator_core
   import tcspg_pkg::*;
#(
   parameter int PWM_SLOTS   = PWM_SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int POS_WIDTH   = POS_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // limit_a[15:0], limit_b[31:16], limit_c[47:32], enable_a[48], enable_b[49],
   // enable_c[50], dir_b_forward[51], heater_duty[55:52]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // step_a_level[0], step_b_level[1], step_c_level[2], dir_b_level[3],
   // position_a[35:4], position_b[67:36], position_c[99:68], heater_level[100],
   // zero fill[103:101]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int EXT_WIDTH = POS_WIDTH + OUT_POS_WIDTH;

   logic                      in_valid_ff;
   logic [REQ_DATA_WIDTH-1:0] in_data_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      dir_ff, dir_in;
   logic                      advance;

   chan_status_type           status_a, status_b, status_c;
   logic [POS_WIDTH-1:0]      pos_a_next, pos_b_next, pos_c_next;
   logic [EXT_WIDTH-1:0]      ext_a, ext_b, ext_c;
   logic                      heater_next;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   tcspg_channel #(.COUNT_WIDTH(COUNT_WIDTH), .POS_WIDTH(POS_WIDTH)) u_chan_a (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .limit    (in_data_ff[15:0]),
      .enable   (in_data_ff[48]),
      .count_up (1'b1),
      .status   (status_a),
      .pos_next (pos_a_next)
   );

   tcspg_channel #(.COUNT_WIDTH(COUNT_WIDTH), .POS_WIDTH(POS_WIDTH)) u_chan_b (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .limit    (in_data_ff[31:16]),
      .enable   (in_data_ff[49]),
      .count_up (in_data_ff[51]),
      .status   (status_b),
      .pos_next (pos_b_next)
   );

   tcspg_channel #(.COUNT_WIDTH(COUNT_WIDTH), .POS_WIDTH(POS_WIDTH)) u_chan_c (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .limit    (in_data_ff[47:32]),
      .enable   (in_data_ff[50]),
      .count_up (1'b1),
      .status   (status_c),
      .pos_next (pos_c_next)
   );

   tcspg_heater_pwm #(.PWM_SLOTS(PWM_SLOTS)) u_heater (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .duty        (in_data_ff[55:52]),
      .heater_next (heater_next)
   );

   always_comb begin
      dir_in = status_b.fire ? ~in_data_ff[51] : dir_ff;
      ext_a  = {{OUT_POS_WIDTH{pos_a_next[POS_WIDTH-1]}}, pos_a_next};
      ext_b  = {{OUT_POS_WIDTH{pos_b_next[POS_WIDTH-1]}}, pos_b_next};
      ext_c  = {{OUT_POS_WIDTH{pos_c_next[POS_WIDTH-1]}}, pos_c_next};
      rsp_data_in = {3'b000, heater_next,
                     ext_c[OUT_POS_WIDTH-1:0], ext_b[OUT_POS_WIDTH-1:0],
                     ext_a[OUT_POS_WIDTH-1:0],
                     dir_in, status_c.level_next, status_b.level_next,
                     status_a.level_next};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            dir_ff <= dir_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("A ticked item did not reach the result register.");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("A waiting input item was dropped.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("Input not ready while the input register is empty.");

   a_dir_follows_b_step: assert property (@(posedge clock) disable iff (reset)
      (advance && status_b.fire) |=> (rsp_data_ff[3] == !$past(in_data_ff[51])))
      else $error("Direction pin does not follow a step of channel B.");
`endif

endmodule
